@@ hdl/srsm_pkg.sv @@
// package for the sensor rate and staleness monitor
// types, field widths, codes and reset values shared by the top level and its checker
// no dependencies
`default_nettype none

package srsm_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;

  localparam int TIME_W    = 32;
  localparam int RATE_W    = 28;
  localparam int EXP_W     = 10;
  localparam int SF_W      = 8;
  localparam int WIN_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W   = 2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_OK    = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ERROR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXP_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STALE_SF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW   = 2'd2;

  localparam logic [EXP_W-1:0] EXP_RATE_RST = 10'd50;
  localparam logic [SF_W-1:0]  STALE_SF_RST = 8'd32;
  localparam logic [WIN_W-1:0] WINDOW_RST   = 16'd5000;

  localparam logic [TIME_W-1:0] NO_MSG_AGE = 32'd999000;
  localparam logic [RATE_W-1:0] RATE_MAX   = 28'hFFF_FFFF;
  localparam int                MS_PER_S   = 1000;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               event_driven;
    logic               has_messages;
    logic [RATE_W-1:0]  rate_q8;
    logic [TIME_W-1:0]  age_ms;
    logic [TIME_W-1:0]  message_count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_WRITE,
    S_REC_READ,
    S_REC_CHECK,
    S_Q_OLD,
    S_Q_NEW,
    S_Q_SPAN,
    S_Q_MUL_AGE,
    S_Q_MUL_N,
    S_Q_MUL_SPAN,
    S_Q_LOW,
    S_Q_DIV,
    S_Q_DONE
  } srsm_state_t;

endpackage

`default_nettype wire

@@ hdl/sensor_rate_staleness_monitor_top.sv @@
// Sliding-window message rate and staleness monitor for one message source. A record request
// (operation 0) writes its millisecond stamp into a circular stamp memory of WINDOW_DEPTH
// entries and then pops stamps older than window_ms; each pop is one read of the stamp
// memory followed by one compare. A query request (operation 1) gives one result with rate,
// age, count and health level. The rate is formed by a bit-serial restoring divider, which
// is skipped when the stored stamps are all equal or fewer than two stamps are stored. A
// query that finishes while the previous result still waits holds in its final state until
// that result is taken. The block takes one request at a time; a finished result waits in
// an output register while the next request is accepted. The stamp memory needs no
// clearing pass after reset.
// depends on srsm_pkg
`default_nettype none

module sensor_rate_staleness_monitor_top #(
  parameter int WINDOW_DEPTH = srsm_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  srsm_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output srsm_pkg::out_t                       out_data,
  input  wire                                  cfg_we,
  input  wire  [srsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [srsm_pkg::CFG_W-1:0]           cfg_wdata
);
  import srsm_pkg::*;

  localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int MB_W    = (IDX_W > EXP_W) ? IDX_W : EXP_W;
  localparam int PROD_W  = TIME_W + MB_W;
  localparam int DIV_W   = IDX_W + 18;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int QW      = (DIV_W > RATE_W) ? DIV_W : RATE_W;
  localparam int THR_W   = SF_W + 10;

  srsm_state_t state_r, state_nxt;

  logic [IDX_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [TIME_W-1:0]  total_r, total_nxt;
  logic [EXP_W-1:0]   exp_r;
  logic [SF_W-1:0]    sf_r;
  logic [WIN_W-1:0]   win_r;
  logic               out_valid_r, out_valid_nxt;

  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [TIME_W-1:0]  age_r, age_nxt;
  logic [TIME_W-1:0]  span_r, span_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [DIV_W-1:0]   num_r, num_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic               stale_r, stale_nxt;
  logic               low_r, low_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [TIME_W-1:0]  mem [WINDOW_DEPTH];
  logic [TIME_W-1:0]  rdata_r;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;

  logic [TIME_W-1:0]  mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [CNT_W-1:0]   ring_off;
  logic [SUM_W-1:0]   ring_sum;
  logic [IDX_W-1:0]   ring_pos;
  logic [IDX_W-1:0]   oldest_inc;
  logic [CNT_W-1:0]   count_m1;
  logic               full;
  logic [TIME_W-1:0]  diff;
  logic [TIME_W:0]    trial;
  logic [QW-1:0]      quo_ext;
  logic [THR_W-1:0]   thresh;
  logic [LEVEL_W-1:0] level;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign ring_sum   = SUM_W'(oldest_r) + SUM_W'(ring_off);
  assign ring_pos   = (ring_sum >= SUM_W'(WINDOW_DEPTH)) ?
                      IDX_W'(ring_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(ring_sum);
  assign oldest_inc = (oldest_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign count_m1   = count_r - 1'b1;
  assign full       = (count_r == CNT_W'(WINDOW_DEPTH));
  assign diff       = time_r - rdata_r;
  assign trial      = {rem_r, num_r[DIV_W-1]};
  assign quo_ext    = QW'(num_r);
  assign thresh     = THR_W'(sf_r) * THR_W'(MS_PER_S);

  always_comb begin
    if (exp_r == '0) begin
      level = LVL_OK;
    end else if (stale_r) begin
      level = LVL_ERROR;
    end else if (low_r) begin
      level = LVL_WARN;
    end else begin
      level = LVL_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    time_nxt      = time_r;
    age_nxt       = age_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    stale_nxt     = stale_r;
    low_nxt       = low_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = oldest_r;
    mem_raddr     = oldest_r;
    ring_off      = count_r;
    mul_a         = age_r;
    mul_b         = MB_W'(exp_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          time_nxt  = in_data.time_ms;
          state_nxt = (in_data.operation == OP_RECORD) ? S_REC_WRITE : S_Q_OLD;
        end
      end
      S_REC_WRITE: begin
        mem_we = 1'b1;
        if (full) begin
          mem_waddr  = oldest_r;
          oldest_nxt = oldest_inc;
        end else begin
          mem_waddr = ring_pos;
          count_nxt = count_r + 1'b1;
        end
        last_nxt = time_r;
        if (total_r != '1) begin
          total_nxt = total_r + 1'b1;
        end
        state_nxt = S_REC_READ;
      end
      S_REC_READ: begin
        mem_re    = 1'b1;
        mem_raddr = oldest_r;
        state_nxt = S_REC_CHECK;
      end
      S_REC_CHECK: begin
        if (count_r != '0 && diff > TIME_W'(win_r)) begin
          oldest_nxt = oldest_inc;
          count_nxt  = count_m1;
          state_nxt  = S_REC_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_OLD: begin
        age_nxt = (total_r == '0) ? NO_MSG_AGE : time_r - last_r;
        if (count_r >= CNT_W'(2)) begin
          mem_re    = 1'b1;
          mem_raddr = oldest_r;
          state_nxt = S_Q_NEW;
        end else begin
          span_nxt  = '0;
          state_nxt = S_Q_MUL_AGE;
        end
      end
      S_Q_NEW: begin
        ring_off  = count_m1;
        mem_re    = 1'b1;
        mem_raddr = ring_pos;
        span_nxt  = rdata_r;
        state_nxt = S_Q_SPAN;
      end
      S_Q_SPAN: begin
        span_nxt  = rdata_r - span_r;
        state_nxt = S_Q_MUL_AGE;
      end
      S_Q_MUL_AGE: begin
        mul_a     = age_r;
        mul_b     = MB_W'(exp_r);
        prod_nxt  = mul_p;
        state_nxt = S_Q_MUL_N;
      end
      S_Q_MUL_N: begin
        stale_nxt = {prod_r, 4'b0} > (PROD_W + 4)'(thresh);
        mul_a     = TIME_W'(MS_PER_S);
        mul_b     = MB_W'(count_m1[IDX_W-1:0]);
        prod_nxt  = mul_p;
        state_nxt = S_Q_MUL_SPAN;
      end
      S_Q_MUL_SPAN: begin
        num_nxt   = {prod_r[IDX_W+9:0], 8'b0};
        mul_a     = span_r;
        mul_b     = MB_W'(exp_r);
        prod_nxt  = mul_p;
        state_nxt = S_Q_LOW;
      end
      S_Q_LOW: begin
        low_nxt     = (total_r > TIME_W'(2)) &&
                      ((span_r == '0) || (PROD_W'(num_r[DIV_W-1:7]) < prod_r));
        rem_nxt     = '0;
        bit_cnt_nxt = DCNT_W'(DIV_W);
        if (span_r == '0) begin
          num_nxt   = '0;
          state_nxt = S_Q_DONE;
        end else begin
          state_nxt = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        if (trial >= {1'b0, span_r}) begin
          rem_nxt = TIME_W'(trial - {1'b0, span_r});
          num_nxt = {num_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[TIME_W-1:0];
          num_nxt = {num_r[DIV_W-2:0], 1'b0};
        end
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == DCNT_W'(1)) begin
          state_nxt = S_Q_DONE;
        end
      end
      S_Q_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.level         = level;
          out_data_nxt.event_driven  = (exp_r == '0);
          out_data_nxt.has_messages  = (total_r != '0);
          out_data_nxt.rate_q8       = (quo_ext > QW'(RATE_MAX)) ? RATE_MAX :
                                       quo_ext[RATE_W-1:0];
          out_data_nxt.age_ms        = age_r;
          out_data_nxt.message_count = total_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      last_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      exp_r       <= EXP_RATE_RST;
      sf_r        <= STALE_SF_RST;
      win_r       <= WINDOW_RST;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_EXP_RATE: exp_r <= cfg_wdata[EXP_W-1:0];
          CFG_IDX_STALE_SF: sf_r  <= cfg_wdata[SF_W-1:0];
          CFG_IDX_WINDOW:   win_r <= cfg_wdata[WIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    time_r     <= time_nxt;
    age_r      <= age_nxt;
    span_r     <= span_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    stale_r    <= stale_nxt;
    low_r      <= low_nxt;
    out_data_r <= out_data_nxt;
  end

  // stamp memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= time_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/srsm_checker.sv @@
// port-level checker for the sensor rate and staleness monitor, with its bind
// depends on srsm_pkg and sensor_rate_staleness_monitor_top
`default_nettype none

module srsm_port_checks (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input srsm_pkg::in_t   in_data,
  input wire             out_valid,
  input wire             out_ready,
  input srsm_pkg::out_t  out_data
);
  import srsm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a request was taken");

  a_event_driven_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_driven |-> out_data.level == LVL_OK)
    else $error("event-driven source reported a fault level");

  a_no_messages: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_messages |->
      out_data.age_ms == NO_MSG_AGE && out_data.message_count == '0 &&
      out_data.rate_q8 == '0)
    else $error("empty source reported age, count or rate");

endmodule

bind sensor_rate_staleness_monitor_top srsm_port_checks u_srsm_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
